[rtl/tpba_pkg.sv]
package tpba_pkg;

   // Default pool depth and configuration reset values
   localparam int unsigned BLOCKS_PER_POOL_DEF = 20;
   localparam logic [15:0] SMALL_BYTES_RESET   = 16'd50;
   localparam logic [15:0] LARGE_BYTES_RESET   = 16'd100;

   // Field widths of the request and response words
   localparam int unsigned BYTES_W  = 16;
   localparam int unsigned INDEX_W  = 6;
   localparam int unsigned FCOUNT_W = 7;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      PSEL_SMALL   = 2'd0,
      PSEL_LARGE   = 2'd1,
      PSEL_HEAP    = 2'd2,
      PSEL_INVALID = 2'd3
   } psel_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_HEAP        = 2'd1,
      ST_DOUBLE_FREE = 2'd2,
      ST_BAD_ADDR    = 2'd3
   } status_type;

   typedef enum logic {
      POOL_SMALL = 1'b0,
      POOL_LARGE = 1'b1
   } pool_type;

   typedef enum logic {
      CSR_SMALL_BYTES = 1'b0,
      CSR_LARGE_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      FSM_IDLE = 4'b0001,
      FSM_TAKE = 4'b0010,
      FSM_HINT = 4'b0100,
      FSM_DONE = 4'b1000
   } fsm_type;

endpackage

[rtl/tpba_req_if.sv]
interface tpba_req_if;
   import tpba_pkg::*;

   logic                 valid;
   logic                 ready;
   cmd_type              command;
   logic [BYTES_W-1:0]   request_bytes;
   psel_type             pool_select;
   logic [INDEX_W-1:0]   block_index;

   modport source (output valid, command, request_bytes, pool_select, block_index,
                   input ready);
   modport sink   (input valid, command, request_bytes, pool_select, block_index,
                   output ready);
endinterface

[rtl/tpba_rsp_if.sv]
interface tpba_rsp_if;
   import tpba_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   pool_type             pool_used;
   logic [INDEX_W-1:0]   block_given;
   logic [FCOUNT_W-1:0]  small_free_count;
   logic [FCOUNT_W-1:0]  large_free_count;

   modport source (output valid, status, pool_used, block_given, small_free_count,
                   large_free_count, input ready);
   modport sink   (input valid, status, pool_used, block_given, small_free_count,
                   large_free_count, output ready);
endinterface

[rtl/tpba_scan.sv]
module tpba_scan #(
   parameter int unsigned BLOCKS_PER_POOL = tpba_pkg::BLOCKS_PER_POOL_DEF,
   parameter int unsigned IDX_W = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic [IDX_W-1:0]           load_idx,
   input  logic                       step,
   input  logic [BLOCKS_PER_POOL-1:0] free_map,
   output logic [IDX_W-1:0]           cur_idx,
   output logic                       hit
);
   import tpba_pkg::*;

   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(BLOCKS_PER_POOL - 1);

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   // Walk down one block a cycle while step is high, wrapping from block zero to the top
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = load_idx;
      end else if (step) begin
         idx_in = (idx_ff == '0) ? TOP_IDX : idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign cur_idx = idx_ff;
   assign hit     = free_map[idx_ff];

endmodule

[rtl/two_pool_block_allocator_top.sv]
// Two-pool fixed block allocator.
// req_chan carries one word per command: allocate (request_bytes picks the
// small or large pool against the two size registers) or free (pool_select
// and block_index name the block). rsp_chan returns one word per request with
// the status, the pool and block handed out or freed, and both free counts.
// The csr_ port writes the small and large size limits; write them only while
// no request is in flight.
// A free is checked and applied when taken, then goes to the response. An
// allocate walks the free map one block per cycle with the shared down-scanner:
// it takes the block on the hint, which always names a free block, then walks
// on to the next free block for the new hint, unless the pool is now empty.
// Requests that fail go straight to the response. One request is worked on at
// a time; req_chan.ready is high only while the sequencer is idle, so the next
// word can be taken in the cycle after the response is loaded.
// The response sits in an output register: a stalled receiver holds the word
// there, and the next request is still accepted and worked on; only its final
// write-back waits for the register to empty.
// Reset (synchronous, active high) frees every block in both pools, sets both
// hints to the top block and loads the size limits with 50 and 100 bytes.
module two_pool_block_allocator_top #(
   parameter int unsigned BLOCKS_PER_POOL = tpba_pkg::BLOCKS_PER_POOL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tpba_req_if.sink                    req_chan,
   tpba_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  tpba_pkg::csr_index_type     csr_index,
   input  logic [tpba_pkg::BYTES_W-1:0] csr_wdata
);
   import tpba_pkg::*;

   localparam int unsigned IDX_W = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
   localparam int unsigned CNT_W = $clog2(BLOCKS_PER_POOL + 1);
   localparam logic [IDX_W-1:0]           TOP_IDX  = IDX_W'(BLOCKS_PER_POOL - 1);
   localparam logic [CNT_W-1:0]           FULL_CNT = CNT_W'(BLOCKS_PER_POOL);
   localparam logic [BLOCKS_PER_POOL-1:0] ALL_FREE = '1;
   localparam logic [BLOCKS_PER_POOL-1:0] ONE_BIT  = BLOCKS_PER_POOL'(1);

   // size limits
   logic [BYTES_W-1:0] small_bytes_ff, small_bytes_in;
   logic [BYTES_W-1:0] large_bytes_ff, large_bytes_in;

   // pool state
   logic [BLOCKS_PER_POOL-1:0] small_map_ff, small_map_in;
   logic [BLOCKS_PER_POOL-1:0] large_map_ff, large_map_in;
   logic [IDX_W-1:0]           small_hint_ff, small_hint_in;
   logic [IDX_W-1:0]           large_hint_ff, large_hint_in;
   logic [CNT_W-1:0]           small_cnt_ff, small_cnt_in;
   logic [CNT_W-1:0]           large_cnt_ff, large_cnt_in;

   // sequencer and the word being built
   fsm_type          state_ff, state_in;
   pool_type         pool_ff, pool_in;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] blk_ff, blk_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   pool_type            rsp_pool_ff, rsp_pool_in;
   logic [INDEX_W-1:0]  rsp_blk_ff, rsp_blk_in;
   logic [FCOUNT_W-1:0] rsp_small_ff, rsp_small_in;
   logic [FCOUNT_W-1:0] rsp_large_ff, rsp_large_in;

   // shared scanner
   logic                       scan_load;
   logic [IDX_W-1:0]           scan_load_idx;
   logic                       scan_step;
   logic [BLOCKS_PER_POOL-1:0] scan_map;
   logic [IDX_W-1:0]           scan_idx;
   logic                       scan_hit;

   logic                       req_fire;
   logic                       rsp_free;
   logic                       idx_ok;
   logic [IDX_W-1:0]           req_idx;
   logic [BLOCKS_PER_POOL-1:0] req_bit;
   logic [BLOCKS_PER_POOL-1:0] scan_bit;
   logic [CNT_W-1:0]           cnt_left;

   tpba_scan #(
      .BLOCKS_PER_POOL (BLOCKS_PER_POOL),
      .IDX_W           (IDX_W)
   ) u_scan (
      .clock    (clock),
      .load     (scan_load),
      .load_idx (scan_load_idx),
      .step     (scan_step),
      .free_map (scan_map),
      .cur_idx  (scan_idx),
      .hit      (scan_hit)
   );

   assign req_chan.ready = (state_ff == FSM_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign idx_ok   = {1'b0, req_chan.block_index} < 7'(BLOCKS_PER_POOL);
   assign req_idx  = req_chan.block_index[IDX_W-1:0];
   assign req_bit  = ONE_BIT << req_idx;
   assign scan_bit = ONE_BIT << scan_idx;
   assign scan_map = (pool_ff == POOL_LARGE) ? large_map_ff : small_map_ff;
   assign cnt_left = ((pool_ff == POOL_LARGE) ? large_cnt_ff : small_cnt_ff) - 1'b1;

   // size limit writes
   always_comb begin
      small_bytes_in = small_bytes_ff;
      large_bytes_in = large_bytes_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SMALL_BYTES: small_bytes_in = csr_wdata;
            CSR_LARGE_BYTES: large_bytes_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pool_in       = pool_ff;
      status_in     = status_ff;
      blk_in        = blk_ff;
      small_map_in  = small_map_ff;
      large_map_in  = large_map_ff;
      small_hint_in = small_hint_ff;
      large_hint_in = large_hint_ff;
      small_cnt_in  = small_cnt_ff;
      large_cnt_in  = large_cnt_ff;
      scan_load     = 1'b0;
      scan_load_idx = small_hint_ff;
      scan_step     = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pool_in   = rsp_pool_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_small_in  = rsp_small_ff;
      rsp_large_in  = rsp_large_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               pool_in   = POOL_SMALL;
               status_in = ST_OK;
               blk_in    = '0;
               state_in  = FSM_DONE;
               if (req_chan.command == CMD_ALLOC) begin
                  if (req_chan.request_bytes <= small_bytes_ff && small_cnt_ff != '0) begin
                     scan_load     = 1'b1;
                     scan_load_idx = small_hint_ff;
                     state_in      = FSM_TAKE;
                  end else if (req_chan.request_bytes > small_bytes_ff &&
                               req_chan.request_bytes <= large_bytes_ff &&
                               large_cnt_ff != '0) begin
                     pool_in       = POOL_LARGE;
                     scan_load     = 1'b1;
                     scan_load_idx = large_hint_ff;
                     state_in      = FSM_TAKE;
                  end else begin
                     status_in = ST_HEAP;
                  end
               end else begin
                  // free: check the address, then the free map
                  if (req_chan.pool_select == PSEL_HEAP) begin
                     status_in = ST_HEAP;
                  end else if (req_chan.pool_select == PSEL_INVALID || !idx_ok) begin
                     status_in = ST_BAD_ADDR;
                  end else begin
                     blk_in = req_idx;
                     if (req_chan.pool_select == PSEL_LARGE) begin
                        pool_in = POOL_LARGE;
                        if (large_map_ff[req_idx]) begin
                           status_in = ST_DOUBLE_FREE;
                        end else begin
                           large_map_in  = large_map_ff | req_bit;
                           large_hint_in = req_idx;
                           large_cnt_in  = large_cnt_ff + 1'b1;
                        end
                     end else begin
                        if (small_map_ff[req_idx]) begin
                           status_in = ST_DOUBLE_FREE;
                        end else begin
                           small_map_in  = small_map_ff | req_bit;
                           small_hint_in = req_idx;
                           small_cnt_in  = small_cnt_ff + 1'b1;
                        end
                     end
                  end
               end
            end
         end
         FSM_TAKE: begin
            // advance until the first free block at or below the hint
            scan_step = 1'b1;
            if (scan_hit) begin
               blk_in = scan_idx;
               if (pool_ff == POOL_LARGE) begin
                  large_map_in = large_map_ff & ~scan_bit;
                  large_cnt_in = cnt_left;
               end else begin
                  small_map_in = small_map_ff & ~scan_bit;
                  small_cnt_in = cnt_left;
               end
               state_in = (cnt_left == '0) ? FSM_DONE : FSM_HINT;
            end
         end
         FSM_HINT: begin
            // find the next free block below, wrapping to the top, for the new hint
            if (scan_hit) begin
               if (pool_ff == POOL_LARGE) begin
                  large_hint_in = scan_idx;
               end else begin
                  small_hint_in = scan_idx;
               end
               state_in = FSM_DONE;
            end else begin
               scan_step = 1'b1;
            end
         end
         FSM_DONE: begin
            // hold the word until the response register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pool_in   = pool_ff;
               rsp_blk_in    = INDEX_W'(blk_ff);
               rsp_small_in  = FCOUNT_W'(small_cnt_ff);
               rsp_large_in  = FCOUNT_W'(large_cnt_ff);
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_IDLE;
         rsp_valid_ff   <= 1'b0;
         small_bytes_ff <= SMALL_BYTES_RESET;
         large_bytes_ff <= LARGE_BYTES_RESET;
         small_map_ff   <= ALL_FREE;
         large_map_ff   <= ALL_FREE;
         small_hint_ff  <= TOP_IDX;
         large_hint_ff  <= TOP_IDX;
         small_cnt_ff   <= FULL_CNT;
         large_cnt_ff   <= FULL_CNT;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         small_bytes_ff <= small_bytes_in;
         large_bytes_ff <= large_bytes_in;
         small_map_ff   <= small_map_in;
         large_map_ff   <= large_map_in;
         small_hint_ff  <= small_hint_in;
         large_hint_ff  <= large_hint_in;
         small_cnt_ff   <= small_cnt_in;
         large_cnt_ff   <= large_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pool_ff       <= pool_in;
      status_ff     <= status_in;
      blk_ff        <= blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pool_ff   <= rsp_pool_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_small_ff  <= rsp_small_in;
      rsp_large_ff  <= rsp_large_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.pool_used        = rsp_pool_ff;
   assign rsp_chan.block_given      = rsp_blk_ff;
   assign rsp_chan.small_free_count = rsp_small_ff;
   assign rsp_chan.large_free_count = rsp_large_ff;

endmodule
